// ===== rtl/wrc_pkg.sv =====
// ----------------------------------------------------------------------------
// wrc_pkg
// Shared constants, types and the sequencer state for the weightless RAM-node
// vote classifier.
// ----------------------------------------------------------------------------
package wrc_pkg;

    // Classifier geometry.
    localparam int ADDR_BITS    = 8;
    localparam int NUM_TABLES   = 8;
    localparam int NUM_CLASSES  = 63;
    localparam int PATTERN_BITS = 64;

    // Fixed field widths of the channels.
    localparam int PATTERN_W = 64;
    localparam int LABEL_W   = 6;
    localparam int WINNER_W  = 7;
    localparam int TOP_W     = 4;
    localparam int MASK_W    = 63;

    // Store layout: one row of table words per table, address is {table, slice}.
    localparam int TBL_W     = (NUM_TABLES > 1) ? $clog2(NUM_TABLES) : 1;
    localparam int MEM_AW    = TBL_W + ADDR_BITS;
    localparam int MEM_DEPTH = NUM_TABLES << ADDR_BITS;

    // Pattern bits at or beyond PATTERN_BITS read as zero.
    localparam logic [PATTERN_W-1:0] PAT_MASK = {PATTERN_W{1'b1}} >> (PATTERN_W - PATTERN_BITS);

    // Vote counters and the argmax scan, LANES classes compared per cycle.
    localparam int VOTE_W     = $clog2(NUM_TABLES + 1);
    localparam int LANES      = 8;
    localparam int SCAN_STEPS = (NUM_CLASSES + LANES - 1) / LANES;
    localparam int VOTE_SLOTS = SCAN_STEPS * LANES;
    localparam int GRP_W      = (SCAN_STEPS > 1) ? $clog2(SCAN_STEPS) : 1;
    localparam int CLS_IW     = $clog2(VOTE_SLOTS);
    localparam int CMP_W      = (VOTE_W > TOP_W) ? VOTE_W : TOP_W;
    localparam logic [TOP_W-1:0] TOP_MAX = {TOP_W{1'b1}};

    // Operation codes.
    localparam logic OP_CLASSIFY = 1'b0;
    localparam logic OP_TRAIN    = 1'b1;

    // Winner code when no class was chosen.
    localparam logic signed [WINNER_W-1:0] NO_WINNER = '1;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_DRAIN,
        ST_SCAN,
        ST_DONE
    } t_state;

    // Write port of the mask store.
    typedef struct packed {
        logic              en;
        logic [MEM_AW-1:0] addr;
        logic [MASK_W-1:0] data;
    } t_mem_wr;

endpackage

// ===== rtl/wrc_in_if.sv =====
// ----------------------------------------------------------------------------
// wrc_in_if
// Input channel: one classify or train transaction per handshake.
// ----------------------------------------------------------------------------
interface wrc_in_if;
    import wrc_pkg::*;

    logic                 valid;
    logic                 ready;
    logic                 op;
    logic [PATTERN_W-1:0] pattern;
    logic [LABEL_W-1:0]   class_label;

    modport source (output valid, output op, output pattern, output class_label,
                    input ready);
    modport sink   (input valid, input op, input pattern, input class_label,
                    output ready);
endinterface

// ===== rtl/wrc_out_if.sv =====
// ----------------------------------------------------------------------------
// wrc_out_if
// Result channel: one result transaction for every input transaction.
// ----------------------------------------------------------------------------
interface wrc_out_if;
    import wrc_pkg::*;

    logic                       valid;
    logic                       ready;
    logic signed [WINNER_W-1:0] winner;
    logic [TOP_W-1:0]           top_votes;
    logic                       label_error;

    modport source (output valid, output winner, output top_votes, output label_error,
                    input ready);
    modport sink   (input valid, input winner, input top_votes, input label_error,
                    output ready);
endinterface

// ===== rtl/wrc_mask_ram.sv =====
// ----------------------------------------------------------------------------
// wrc_mask_ram
// Class-mask store: one write port and one read port with registered read
// data. Holds one 63-bit class mask per RAM-node word.
// ----------------------------------------------------------------------------
module wrc_mask_ram (
    input  logic                          i_clk,
    input  wrc_pkg::t_mem_wr              i_wr,
    input  logic [wrc_pkg::MEM_AW-1:0]    i_raddr,
    output logic [wrc_pkg::MASK_W-1:0]    o_rdata
);
    import wrc_pkg::*;

    logic [MASK_W-1:0] r_mem [MEM_DEPTH];
    logic [MASK_W-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/wisard_ram_vote_classifier_top.sv =====
// ----------------------------------------------------------------------------
// wisard_ram_vote_classifier_top
// Weightless RAM-node classifier. After reset the block clears all MEM_DEPTH
// words (2048 at the default geometry) of the class-mask store and
// accepts no transaction meanwhile. It then works on one transaction at a
// time through a single store read port, reading each table in turn.
// A train transaction with a valid label does a read-modify-write of each
// addressed word; one with a rejected label reads nothing and goes straight
// to its result. A classify transaction reads one word per table into 63
// vote counters, then runs an argmax scan comparing eight classes a cycle.
// The result is held in an output register, so it may wait to be taken.
// ----------------------------------------------------------------------------
module wisard_ram_vote_classifier_top (
    input  logic  i_clk,
    input  logic  i_rst_n,
    wrc_in_if.sink    i_in,
    wrc_out_if.source o_out
);
    import wrc_pkg::*;

    t_state r_state;
    t_state n_state;

    // Transaction registers.
    logic                 r_op;
    logic [PATTERN_W-1:0] r_pat;
    logic [MASK_W-1:0]    r_bit;
    logic                 r_err;
    logic [TBL_W-1:0]     r_tbl;
    logic [MEM_AW-1:0]    r_clr;

    // Read pipeline tracking.
    logic                 r_rd_vld;
    logic [MEM_AW-1:0]    r_rd_addr;
    logic [MASK_W-1:0]    mem_q;

    // Votes and argmax.
    logic [VOTE_W-1:0]          r_votes [VOTE_SLOTS];
    logic [GRP_W-1:0]           r_grp;
    logic [CLS_IW-1:0]          r_base;
    logic [VOTE_W-1:0]          r_best;
    logic signed [WINNER_W-1:0] r_win;
    logic [VOTE_W-1:0]          n_best;
    logic signed [WINNER_W-1:0] n_win;

    // Output register.
    logic                       r_out_vld;
    logic signed [WINNER_W-1:0] r_out_win;
    logic [TOP_W-1:0]           r_out_top;
    logic                       r_out_err;

    // Control from the sequencer.
    logic              accept;
    logic              out_free;
    logic              rd_last;
    logic              scan_last;
    logic              clr_last;
    logic              load_out;
    t_mem_wr           mem_wr;
    logic [MEM_AW-1:0] mem_raddr;
    logic [CMP_W-1:0]  best_ext;
    logic [TOP_W-1:0]  top_sat;

    assign accept    = i_in.valid && i_in.ready;
    assign out_free  = !r_out_vld || o_out.ready;
    assign rd_last   = (r_tbl == TBL_W'(NUM_TABLES - 1));
    assign scan_last = (r_grp == GRP_W'(SCAN_STEPS - 1));
    assign clr_last  = (r_clr == MEM_AW'(MEM_DEPTH - 1));

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                if (clr_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_in.valid) begin
                    if (i_in.op == OP_TRAIN && i_in.class_label >= LABEL_W'(NUM_CLASSES)) begin
                        n_state = ST_DONE;
                    end else begin
                        n_state = ST_READ;
                    end
                end
            end
            ST_READ: begin
                if (rd_last) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                n_state = (r_op == OP_TRAIN) ? ST_DONE : ST_SCAN;
            end
            ST_SCAN: begin
                if (scan_last) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Sequencer outputs: handshake, store ports and output load.
    always_comb begin
        i_in.ready = 1'b0;
        load_out   = 1'b0;
        mem_raddr  = {r_tbl, r_pat[ADDR_BITS-1:0]};
        mem_wr.en   = 1'b0;
        mem_wr.addr = r_rd_addr;
        mem_wr.data = mem_q | r_bit;
        case (r_state)
            ST_CLEAR: begin
                mem_wr.en   = 1'b1;
                mem_wr.addr = r_clr;
                mem_wr.data = '0;
            end
            ST_IDLE: begin
                i_in.ready = 1'b1;
            end
            ST_DONE: begin
                load_out = out_free;
            end
            default: begin
            end
        endcase
        // Train write-back of the word read in the previous cycle.
        if (r_rd_vld && r_op == OP_TRAIN) begin
            mem_wr.en = 1'b1;
        end
    end

    wrc_mask_ram u_mask_ram (
        .i_clk   (i_clk),
        .i_wr    (mem_wr),
        .i_raddr (mem_raddr),
        .o_rdata (mem_q)
    );

    // State and control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_CLEAR;
            r_clr     <= '0;
            r_rd_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_rd_vld <= (r_state == ST_READ);
            if (r_state == ST_CLEAR) begin
                r_clr <= r_clr + MEM_AW'(1);
            end
            if (load_out) begin
                r_out_vld <= 1'b1;
            end else if (o_out.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // Transaction capture and table walk.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op  <= i_in.op;
            r_pat <= i_in.pattern & PAT_MASK;
            r_bit <= MASK_W'(1) << i_in.class_label;
            r_err <= (i_in.op == OP_TRAIN) && (i_in.class_label >= LABEL_W'(NUM_CLASSES));
            r_tbl <= '0;
        end else if (r_state == ST_READ) begin
            r_pat <= r_pat >> ADDR_BITS;
            r_tbl <= r_tbl + TBL_W'(1);
        end
        if (r_state == ST_READ) begin
            r_rd_addr <= mem_raddr;
        end
    end

    // Argmax over one group of LANES classes; strict compare keeps the lowest index.
    always_comb begin
        n_best = r_best;
        n_win  = r_win;
        for (int j = 0; j < LANES; j++) begin
            if (r_votes[j] > n_best) begin
                n_best = r_votes[j];
                n_win  = WINNER_W'(r_base + CLS_IW'(j));
            end
        end
    end

    // Vote counters: cleared on acceptance, counted from read data, shifted by the scan.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            for (int i = 0; i < VOTE_SLOTS; i++) begin
                r_votes[i] <= '0;
            end
            r_best <= '0;
            r_win  <= NO_WINNER;
            r_grp  <= '0;
            r_base <= '0;
        end else if (r_state == ST_SCAN) begin
            for (int i = 0; i < VOTE_SLOTS - LANES; i++) begin
                r_votes[i] <= r_votes[i + LANES];
            end
            for (int i = VOTE_SLOTS - LANES; i < VOTE_SLOTS; i++) begin
                r_votes[i] <= '0;
            end
            r_best <= n_best;
            r_win  <= n_win;
            r_grp  <= r_grp + GRP_W'(1);
            r_base <= r_base + CLS_IW'(LANES);
        end else if (r_rd_vld && r_op == OP_CLASSIFY) begin
            for (int c = 0; c < NUM_CLASSES; c++) begin
                r_votes[c] <= r_votes[c] + VOTE_W'(mem_q[c]);
            end
        end
    end

    // Vote count saturates at the width of the result field.
    assign best_ext = CMP_W'(r_best);
    assign top_sat  = (best_ext > CMP_W'(TOP_MAX)) ? TOP_MAX : best_ext[TOP_W-1:0];

    // Output register.
    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out_win <= r_win;
            r_out_top <= top_sat;
            r_out_err <= r_err;
        end
    end

    assign o_out.valid       = r_out_vld;
    assign o_out.winner      = r_out_win;
    assign o_out.top_votes   = r_out_top;
    assign o_out.label_error = r_out_err;

endmodule

// ===== tb/sv/wrc_vote_checker.sv =====
// ----------------------------------------------------------------------------
// wrc_vote_checker
// Watches both channels of the weightless RAM-node classifier. It keeps its
// own copy of the class-mask store, works out the result of every accepted
// input transaction and compares each accepted result, field by field, with
// the oldest result still outstanding.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module wrc_vote_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    input  logic                                i_in_ready,
    input  logic                                i_in_op,
    input  logic [wrc_pkg::PATTERN_W-1:0]       i_in_pattern,
    input  logic [wrc_pkg::LABEL_W-1:0]         i_in_label,
    input  logic                                i_out_valid,
    input  logic                                i_out_ready,
    input  logic signed [wrc_pkg::WINNER_W-1:0] i_winner,
    input  logic [wrc_pkg::TOP_W-1:0]           i_top_votes,
    input  logic                                i_label_error,
    output int                                  o_fail_count,
    output int                                  o_pending,
    output int                                  o_checked
);
    import wrc_pkg::*;

    // One expected result transaction.
    typedef struct packed {
        logic signed [WINNER_W-1:0] winner;
        logic [TOP_W-1:0]           top_votes;
        logic                       label_error;
    } t_vote_result;

    // Local copy of the class masks, one word per table address.
    logic [MASK_W-1:0] class_store [NUM_TABLES << ADDR_BITS];
    t_vote_result      pending_results [$];
    int                fail_count = 0;
    int                checked    = 0;

    // Prints one line per mismatch and counts it.
    task automatic report_mismatch(input string msg);
        $display("[%0t] MISMATCH: %s", $realtime, msg);
        fail_count++;
    endtask

    // Store word that a pattern addresses in one table. Address bits that
    // fall beyond the pattern read as zero.
    function automatic int word_of(input logic [PATTERN_W-1:0] pattern, input int tbl);
        int addr;
        int pos;
        addr = 0;
        for (int b = 0; b < ADDR_BITS; b++) begin
            pos = tbl * ADDR_BITS + b;
            if (pos < PATTERN_BITS && pos < PATTERN_W && pattern[pos]) begin
                addr |= 1 << b;
            end
        end
        return (tbl << ADDR_BITS) + addr;
    endfunction

    // Applies one transaction to the local store and returns its result.
    function automatic t_vote_result predict_vote(input logic op,
                                                  input logic [PATTERN_W-1:0] pattern,
                                                  input logic [LABEL_W-1:0] label);
        t_vote_result      res;
        int                votes [NUM_CLASSES];
        int                best;
        logic [MASK_W-1:0] word;
        res.winner      = NO_WINNER;
        res.top_votes   = '0;
        res.label_error = 1'b0;
        if (op == OP_TRAIN) begin
            // A label outside the class range is flagged and writes nothing.
            if (int'(label) >= NUM_CLASSES) begin
                res.label_error = 1'b1;
            end else begin
                for (int t = 0; t < NUM_TABLES; t++) begin
                    class_store[word_of(pattern, t)][label] = 1'b1;
                end
            end
        end else begin
            for (int c = 0; c < NUM_CLASSES; c++) begin
                votes[c] = 0;
            end
            for (int t = 0; t < NUM_TABLES; t++) begin
                word = class_store[word_of(pattern, t)];
                for (int c = 0; c < NUM_CLASSES; c++) begin
                    if (word[c]) begin
                        votes[c]++;
                    end
                end
            end
            // The strict comparison keeps the lowest class on a tie.
            best = 0;
            for (int c = 0; c < NUM_CLASSES; c++) begin
                if (votes[c] > best) begin
                    best       = votes[c];
                    res.winner = WINNER_W'(c);
                end
            end
            res.top_votes = (best > int'(TOP_MAX)) ? TOP_MAX : TOP_W'(best);
        end
        return res;
    endfunction

    // Results are checked before new transactions are predicted, so a
    // result that appears with nothing outstanding is always caught.
    always @(posedge i_clk) begin
        t_vote_result want;
        if (!i_rst_n) begin
            foreach (class_store[w]) begin
                class_store[w] = '0;
            end
            pending_results.delete();
        end else begin
            if (i_out_valid === 1'b1 && i_out_ready === 1'b1) begin
                if (pending_results.size() == 0) begin
                    report_mismatch($sformatf("result with no transaction outstanding: winner %0d",
                                              i_winner));
                end else begin
                    want = pending_results.pop_front();
                    if (i_winner !== want.winner) begin
                        report_mismatch($sformatf("winner %0d, expected %0d",
                                                  i_winner, want.winner));
                    end
                    if (i_top_votes !== want.top_votes) begin
                        report_mismatch($sformatf("top_votes %0d, expected %0d",
                                                  i_top_votes, want.top_votes));
                    end
                    if (i_label_error !== want.label_error) begin
                        report_mismatch($sformatf("label_error %b, expected %b",
                                                  i_label_error, want.label_error));
                    end
                    checked++;
                end
            end
            if (i_in_valid === 1'b1 && i_in_ready === 1'b1) begin
                pending_results.push_back(predict_vote(i_in_op, i_in_pattern, i_in_label));
            end
        end
        o_pending    <= pending_results.size();
        o_fail_count <= fail_count;
        o_checked    <= checked;
    end

endmodule

// ===== tb/sv/wisard_ram_vote_classifier_top_tb.sv =====
// ----------------------------------------------------------------------------
// wisard_ram_vote_classifier_top_tb
// Drives classify and train transactions into the classifier, first a short
// directed sequence and then random traffic built around a pool of noisy
// prototype patterns. Both channels idle at random, and the result side
// holds off once for a long stretch. The checker beside the block predicts
// and compares every result.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module wisard_ram_vote_classifier_top_tb;
    import wrc_pkg::*;

    localparam int RANDOM_ITEMS = 630;
    localparam int CYCLE_LIMIT  = 250000;
    localparam int HOLD_CYCLES  = 200;
    localparam int HOLD_AT      = 120;
    localparam int PROTOS       = 12;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    wrc_in_if  in_ch ();
    wrc_out_if out_ch ();

    int   fail_count;
    int   pending;
    int   checked;
    int   cycle_count = 0;
    int   n_classify  = 0;
    int   n_train     = 0;
    int   n_bad       = 0;
    bit   sender_flat = 1'b0;

    logic [PATTERN_W-1:0] proto_pattern [PROTOS];
    logic [LABEL_W-1:0]   proto_label   [PROTOS];

    wisard_ram_vote_classifier_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    wrc_vote_checker vote_chk (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (in_ch.valid),
        .i_in_ready    (in_ch.ready),
        .i_in_op       (in_ch.op),
        .i_in_pattern  (in_ch.pattern),
        .i_in_label    (in_ch.class_label),
        .i_out_valid   (out_ch.valid),
        .i_out_ready   (out_ch.ready),
        .i_winner      (out_ch.winner),
        .i_top_votes   (out_ch.top_votes),
        .i_label_error (out_ch.label_error),
        .o_fail_count  (fail_count),
        .o_pending     (pending),
        .o_checked     (checked)
    );

    // Clock, 12 ns period.
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("wisard_ram_vote_classifier_top regression: fail");
            $finish;
        end
    end

    function automatic logic [PATTERN_W-1:0] rand_pattern();
        return {$urandom, $urandom};
    endfunction

    // Flips up to five random bits of a pattern.
    function automatic logic [PATTERN_W-1:0] add_noise(input logic [PATTERN_W-1:0] base);
        logic [PATTERN_W-1:0] p;
        int                   flips;
        int                   idx;
        p     = base;
        flips = $urandom_range(0, 5);
        repeat (flips) begin
            idx    = $urandom_range(0, PATTERN_W - 1);
            p[idx] = ~p[idx];
        end
        return p;
    endfunction

    // Offers one transaction after a random gap and waits until it is taken.
    // With no gap, valid simply stays high for the next transaction.
    task automatic send_item(input logic op, input logic [PATTERN_W-1:0] pat,
                             input logic [LABEL_W-1:0] lbl);
        int gap;
        gap = sender_flat ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.op          <= op;
        in_ch.pattern     <= pat;
        in_ch.class_label <= lbl;
        do @(posedge i_clk); while (in_ch.ready !== 1'b1);
        if (op == OP_CLASSIFY) begin
            n_classify++;
        end else if (int'(lbl) >= NUM_CLASSES) begin
            n_bad++;
        end else begin
            n_train++;
        end
    endtask

    // Result side: random stalls, stretches without stalls, and one long
    // hold-off that backs the block up into its input.
    initial begin
        int stall;
        int taken;
        bit flat;
        taken = 0;
        flat  = 1'b0;
        out_ch.ready <= 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            if (taken % 40 == 0) begin
                flat = ($urandom_range(0, 2) == 0);
            end
            stall = flat ? 0 : $urandom_range(0, 4);
            if (taken == HOLD_AT) begin
                stall = HOLD_CYCLES;
            end
            if (stall > 0) begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            out_ch.ready <= 1'b1;
            do @(posedge i_clk); while (out_ch.valid !== 1'b1);
            taken++;
        end
    end

    // Stimulus and verdict.
    initial begin
        int                   kind;
        int                   k;
        logic [PATTERN_W-1:0] pat;
        in_ch.valid       <= 1'b0;
        in_ch.op          <= OP_CLASSIFY;
        in_ch.pattern     <= '0;
        in_ch.class_label <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty store, label extremes, rejected label, ties,
        // partial matches and the end bits of the pattern.
        send_item(OP_CLASSIFY, '0, 6'd0);
        send_item(OP_CLASSIFY, '1, 6'd0);
        send_item(OP_TRAIN, '0, 6'd0);
        send_item(OP_TRAIN, '1, 6'd62);
        send_item(OP_TRAIN, 64'h5555_5555_5555_5555, 6'd63);
        send_item(OP_CLASSIFY, 64'h5555_5555_5555_5555, 6'd0);
        send_item(OP_CLASSIFY, '0, 6'd0);
        send_item(OP_CLASSIFY, '1, 6'd0);
        send_item(OP_TRAIN, '0, 6'd5);
        send_item(OP_CLASSIFY, '0, 6'd63);
        send_item(OP_TRAIN, 64'h0000_0000_0000_00FF, 6'd62);
        send_item(OP_CLASSIFY, '0, 6'd0);
        send_item(OP_CLASSIFY, 64'hFFFF_FFFF_0000_0000, 6'd0);
        send_item(OP_TRAIN, 64'hAAAA_AAAA_AAAA_AAAA, 6'd31);
        send_item(OP_TRAIN, 64'hAAAA_AAAA_AAAA_AAAA, 6'd32);
        send_item(OP_CLASSIFY, 64'hAAAA_AAAA_AAAA_AAAA, 6'd0);
        send_item(OP_TRAIN, 64'h8000_0000_0000_0001, 6'd1);
        send_item(OP_CLASSIFY, 64'h8000_0000_0000_0001, 6'd0);
        send_item(OP_CLASSIFY, 64'h0123_4567_89AB_CDEF, 6'd0);
        send_item(OP_TRAIN, 64'hFEDC_BA98_7654_3210, 6'd42);
        send_item(OP_CLASSIFY, 64'hFEDC_BA98_7654_3210, 6'd0);

        // Prototype pool for the random part, with both label extremes in it.
        for (int p = 0; p < PROTOS; p++) begin
            proto_pattern[p] = rand_pattern();
            proto_label[p]   = LABEL_W'($urandom_range(0, NUM_CLASSES - 1));
        end
        proto_label[0] = 6'd0;
        proto_label[1] = 6'd62;

        // Random part: mostly training and classifying noisy prototypes, the
        // rest rejected labels and unrelated patterns.
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if (i % 50 == 0) begin
                sender_flat = ($urandom_range(0, 3) == 0);
            end
            kind = $urandom_range(0, 99);
            k    = $urandom_range(0, PROTOS - 1);
            pat  = add_noise(proto_pattern[k]);
            if (kind < 40) begin
                send_item(OP_TRAIN, pat, proto_label[k]);
            end else if (kind < 45) begin
                send_item(OP_TRAIN, rand_pattern(), 6'd63);
            end else if (kind < 85) begin
                send_item(OP_CLASSIFY, pat, LABEL_W'($urandom_range(0, 63)));
            end else if (kind < 93) begin
                send_item(OP_CLASSIFY, rand_pattern(), LABEL_W'($urandom_range(0, 63)));
            end else begin
                send_item(OP_TRAIN, rand_pattern(), LABEL_W'($urandom_range(0, 63)));
            end
        end
        in_ch.valid <= 1'b0;

        // Drain the outstanding results, then allow for any stray ones.
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);

        $display("Run covered %0d classify, %0d train and %0d rejected-label transactions.",
                 n_classify, n_train, n_bad);
        $display("%0d results checked, %0d mismatches, one %0d-cycle result hold-off.",
                 checked, fail_count, HOLD_CYCLES);
        if (fail_count == 0) begin
            $display("wisard_ram_vote_classifier_top regression: pass");
        end else begin
            $display("wisard_ram_vote_classifier_top regression: fail");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/wrc_pkg.sv
rtl/wrc_in_if.sv
rtl/wrc_out_if.sv
rtl/wrc_mask_ram.sv
rtl/wisard_ram_vote_classifier_top.sv
tb/sv/wrc_vote_checker.sv
tb/sv/wisard_ram_vote_classifier_top_tb.sv
